// File: src/uat_pkg.sv
// Shared codes, widths and the search token type for the unordered array table.
package uat_pkg;

    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 9;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // Control part of the token that walks down the row of cells.
    typedef struct packed {
        logic valid;
        logic found;
    } uat_tok_t;

endpackage

// File: src/uat_cell.sv
// One table cell: holds a single entry and passes the search token to its neighbor.
module uat_cell
    import uat_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 8,
    parameter int CNT_W = 9
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [WORD_W-1:0] word,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [CNT_W-1:0]         count,
    input  uat_tok_t                 tok_in,
    input  logic [IDX_W-1:0]         hit_in,
    input  logic signed [WORD_W-1:0] rdata_in,
    input  logic signed [WORD_W-1:0] last_in,
    output uat_tok_t                 tok_out,
    output logic [IDX_W-1:0]         hit_out,
    output logic signed [WORD_W-1:0] rdata_out,
    output logic signed [WORD_W-1:0] last_out,
    input  logic                     wr_en,
    input  logic signed [WORD_W-1:0] wr_word
);

    localparam int SW = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [SW-1:0]    MY_POS  = SW'(INDEX);
    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);
    localparam logic [IDX_W-1:0] MY_HIT  = IDX_W'(INDEX);

    logic signed [WORD_W-1:0] entry_reg;
    uat_tok_t                 tok_reg, tok_next;
    logic [IDX_W-1:0]         hit_reg, hit_next;
    logic signed [WORD_W-1:0] rdata_reg, rdata_next;
    logic signed [WORD_W-1:0] last_reg, last_next;
    logic                     in_range;
    logic                     match;

    assign in_range = (MY_IDX < count);
    assign match    = tok_in.valid && in_range && !tok_in.found && (entry_reg == word);

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found | match;
        hit_next       = match ? MY_HIT : hit_in;
        rdata_next     = (tok_in.valid && (SW'(slot) == MY_POS)) ? entry_reg : rdata_in;
        last_next      = (tok_in.valid && in_range && (count == MY_NEXT)) ? entry_reg : last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        rdata_reg <= rdata_next;
        last_reg  <= last_next;
        if (wr_en)
        begin
            entry_reg <= wr_word;
        end
    end

    assign tok_out   = tok_reg;
    assign hit_out   = hit_reg;
    assign rdata_out = rdata_reg;
    assign last_out  = last_reg;

endmodule

// File: src/unordered_array_table.sv
// A command word is taken only in idle; in_stall stays high until the command has committed,
// so a new word is not accepted before the last one is through. Each command latches its word,
// sends a token that walks once through all CAPACITY cells, one cell per cycle, captures the tail
// of the row, then commits and loads the result word once the output register is free.
// Reset (rst_n, asynchronous, active low) empties the table and clears all control;
// the entry registers themselves are not cleared, as only slots below the count are read.
module unordered_array_table
    import uat_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CMD_W-1:0]           command,
    input  logic [SLOT_W-1:0]          slot_in,
    input  logic signed [WORD_W-1:0]   word_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [SLOT_W-1:0]          slot_out,
    output logic signed [WORD_W-1:0]   word_out,
    output logic [FILL_W-1:0]          fill_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Sequencer states: waiting for a command, sweeping the cells, and
    // committing the write and the result word.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SWEEP  = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic signed [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     launch_reg, launch_next;

    // Sweep results captured from the tail of the row.
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         hit_reg, hit_next;
    logic signed [WORD_W-1:0] rdata_reg, rdata_next;
    logic signed [WORD_W-1:0] last_reg, last_next;

    // Output register; it lets the next command in while a result waits.
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [SLOT_W-1:0]        slot_out_reg, slot_out_next;
    logic signed [WORD_W-1:0] word_out_reg, word_out_next;

    // Token chain: element 0 is the launch point, element k+1 is the output of cell k.
    uat_tok_t                 tok_chain   [CAPACITY+1];
    logic [IDX_W-1:0]         hit_chain   [CAPACITY+1];
    logic signed [WORD_W-1:0] rdata_chain [CAPACITY+1];
    logic signed [WORD_W-1:0] last_chain  [CAPACITY+1];

    // Broadcast write port into the row; the enable of each cell is decoded from its own index.
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic signed [WORD_W-1:0] wr_word;

    logic in_accept;
    logic finish_go;
    logic slot_ok;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign finish_go = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    assign slot_ok   = (SW'(slot_reg) < SW'(count_reg));

    // A fresh token enters cell 0 in the cycle after the command is accepted, as launch_reg is latched with it.
    assign tok_chain[0].valid = launch_reg;
    assign tok_chain[0].found = 1'b0;
    assign hit_chain[0]       = '0;
    assign rdata_chain[0]     = '0;
    assign last_chain[0]      = '0;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            uat_cell #(
                .INDEX (k),
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .word      (word_reg),
                .slot      (slot_reg),
                .count     (count_reg),
                .tok_in    (tok_chain[k]),
                .hit_in    (hit_chain[k]),
                .rdata_in  (rdata_chain[k]),
                .last_in   (last_chain[k]),
                .tok_out   (tok_chain[k+1]),
                .hit_out   (hit_chain[k+1]),
                .rdata_out (rdata_chain[k+1]),
                .last_out  (last_chain[k+1]),
                .wr_en     (wr_en && (wr_idx == IDX_W'(k))),
                .wr_word   (wr_word)
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        word_next      = word_reg;
        count_next     = count_reg;
        launch_next    = 1'b0;
        found_next     = found_reg;
        hit_next       = hit_reg;
        rdata_next     = rdata_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        slot_out_next  = slot_out_reg;
        word_out_next  = word_out_reg;
        wr_en          = 1'b0;
        wr_idx         = '0;
        wr_word        = word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next    = command;
                    slot_next   = slot_in;
                    word_next   = word_in;
                    launch_next = 1'b1;
                    state_next  = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                // The token leaves the last cell with the first match, the
                // addressed entry and the last live entry.
                if (tok_chain[CAPACITY].valid)
                begin
                    found_next = tok_chain[CAPACITY].found;
                    hit_next   = hit_chain[CAPACITY];
                    rdata_next = rdata_chain[CAPACITY];
                    last_next  = last_chain[CAPACITY];
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    slot_out_next  = '0;
                    word_out_next  = '0;
                    state_next     = S_IDLE;
                    unique case (cmd_reg)
                        CMD_APPEND:
                        begin
                            if (count_reg >= CNT_FULL)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_idx        = IDX_W'(count_reg);
                                slot_out_next = SLOT_W'(count_reg);
                                count_next    = count_reg + CNT_ONE;
                            end
                        end
                        CMD_SET:
                        begin
                            if (slot_ok)
                            begin
                                wr_en  = 1'b1;
                                wr_idx = IDX_W'(slot_reg);
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        CMD_DELETE:
                        begin
                            // The last entry fills the hole left by the match.
                            if (found_reg)
                            begin
                                wr_en      = 1'b1;
                                wr_idx     = hit_reg;
                                wr_word    = last_reg;
                                count_next = count_reg - CNT_ONE;
                            end
                            else
                            begin
                                status_next = ST_MISSING;
                            end
                        end
                        CMD_GET:
                        begin
                            if (slot_ok)
                            begin
                                word_out_next = rdata_reg;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (found_reg)
                            begin
                                slot_out_next = SLOT_W'(hit_reg);
                            end
                            else
                            begin
                                status_next = ST_MISSING;
                            end
                        end
                        default:
                        begin
                            // Unused command codes leave the table alone.
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        word_reg     <= word_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
        rdata_reg    <= rdata_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        word_out_reg <= word_out_next;
    end

    // The fill count reflects the table after the command; it only moves
    // when a result is loaded, so it stays steady while a result waits.
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_out   = slot_out_reg;
    assign word_out   = word_out_reg;
    assign fill_count = FILL_W'(count_reg);

endmodule
